// ===== src/slid_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// slid_pkg: shared types and codes of the sorted list core
// Command and result words, status and opcode codes, and the per-cell control
// word that steps the row of list cells.
// ----------------------------------------------------------------------------
package slid_pkg;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  localparam logic [1:0] ST_INSERTED  = 2'd0;
  localparam logic [1:0] ST_DELETED   = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic               op;
    logic signed [31:0] value;
  } cmd_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] entry_count;
  } result_word_t;

  // sample: capture compare flags; ins / del: apply the shift this cycle
  typedef struct packed {
    logic sample;
    logic ins;
    logic del;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== src/sorted_list_insert_delete_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_list_insert_delete_core: bounded ascending list of signed words
// Insert places a value ahead of the first entry not less than it; delete
// removes the first equal entry. One result word per command word.
// ----------------------------------------------------------------------------
// Sequence: the accepting edge latches the command word, the compare cycle (pend)
//   registers the cell flags, and the update cycle (upd) shifts the row and
//   registers done and the result word together.
// Busy is high for the compare cycle only, and a new command word can be taken
//   while the update is applied. Every cell registers its compare flags in the
//   compare cycle; the update cycle reduces them and shifts the row.
// Reset: clears the count and all valid bits; the list starts empty.
// The receiver cannot stall; done is high for exactly one cycle per result.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete_core #(
  parameter int CAPACITY = 64
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      start,
  output logic                     busy,
  input  wire slid_pkg::cmd_word_t cmd,
  output logic                     done,
  output slid_pkg::result_word_t   result
);

  localparam int CW = $clog2(CAPACITY + 1);

  // Command held for the compare and update cycles
  logic               op_q;
  logic signed [31:0] value_q;

  // Sequencing: pend is the compare cycle, upd the update cycle
  logic pend;
  logic upd;

  logic [CW-1:0] occ;

  slid_pkg::cell_ctrl_t ctrl;

  logic signed [31:0] cell_val   [CAPACITY];
  logic               cell_valid [CAPACITY];
  logic               cell_lt    [CAPACITY];
  logic [CAPACITY-1:0] cell_hit;

  logic found;
  logic full;
  logic accept;

  assign busy   = pend;
  assign accept = start & ~pend;
  assign found  = |cell_hit;
  assign full   = (occ == CW'(CAPACITY));

  always_comb begin
    ctrl.sample = pend;
    ctrl.ins    = upd & (op_q == slid_pkg::OP_INSERT) & ~full;
    ctrl.del    = upd & (op_q == slid_pkg::OP_DELETE) & found;
  end

  // Row of cells; the ends see an always-smaller left and an empty right
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] lval;
    logic               lvalid;
    logic               llt;
    logic signed [31:0] rval;
    logic               rvalid;

    if (i == 0) begin : g_first
      assign lval   = '0;
      assign lvalid = 1'b0;
      assign llt    = 1'b1;
    end else begin : g_mid_l
      assign lval   = cell_val[i-1];
      assign lvalid = cell_valid[i-1];
      assign llt    = cell_lt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign rval   = '0;
      assign rvalid = 1'b0;
    end else begin : g_mid_r
      assign rval   = cell_val[i+1];
      assign rvalid = cell_valid[i+1];
    end

    slid_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .key         (value_q),
      .left_val    (lval),
      .left_valid  (lvalid),
      .left_lt     (llt),
      .right_val   (rval),
      .right_valid (rvalid),
      .val         (cell_val[i]),
      .valid       (cell_valid[i]),
      .lt          (cell_lt[i]),
      .hit         (cell_hit[i])
    );
  end

  // Latch the command word on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= cmd.op;
      value_q <= cmd.value;
    end
  end

  // Advance the sequence, update the count and register the done strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      upd  <= 1'b0;
      done <= 1'b0;
      occ  <= '0;
    end else begin
      pend <= accept;
      upd  <= pend;
      done <= upd;
      if (ctrl.ins) begin
        occ <= occ + CW'(1);
      end else if (ctrl.del) begin
        occ <= occ - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      if (op_q == slid_pkg::OP_INSERT) begin
        if (full) begin
          result.status      <= slid_pkg::ST_FULL;
          result.entry_count <= 7'(occ);
        end else begin
          result.status      <= slid_pkg::ST_INSERTED;
          result.entry_count <= 7'(occ + CW'(1));
        end
      end else begin
        if (found) begin
          result.status      <= slid_pkg::ST_DELETED;
          result.entry_count <= 7'(occ - CW'(1));
        end else begin
          result.status      <= slid_pkg::ST_NOT_FOUND;
          result.entry_count <= 7'(occ);
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/slid_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// slid_cell: one slot of the sorted list
// Holds one value and its valid bit, compares it with the broadcast key, and
// shifts toward either neighbor on insert or delete.
// ----------------------------------------------------------------------------
module slid_cell (
  input  wire                     clk,
  input  wire                     rst,
  input  wire slid_pkg::cell_ctrl_t ctrl,
  input  wire logic signed [31:0] key,
  input  wire logic signed [31:0] left_val,
  input  wire                     left_valid,
  input  wire                     left_lt,
  input  wire logic signed [31:0] right_val,
  input  wire                     right_valid,
  output logic signed [31:0]      val,
  output logic                    valid,
  output logic                    lt,
  output logic                    hit
);

  logic eq;

  // first equal entry: equal here, and everything to the left is smaller
  assign hit = eq & ~lt & left_lt;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      lt    <= 1'b0;
      eq    <= 1'b0;
    end else begin
      if (ctrl.sample) begin
        lt <= valid & (val < key);
        eq <= valid & (val == key);
      end
      if (ctrl.ins && !lt) begin
        // open the gap at the insert point, shift the rest right
        valid <= left_lt ? 1'b1 : left_valid;
      end else if (ctrl.del && !lt) begin
        valid <= right_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ins && !lt) begin
      val <= left_lt ? key : left_val;
    end else if (ctrl.del && !lt) begin
      val <= right_val;
    end
  end

endmodule
`default_nettype wire
